// ----- src/hsu_pkg.sv -----
package hsu_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // one classified input beat on its way from the front to the sort engine
    typedef struct packed {
        logic signed [31:0] value;
        logic               keep;
        logic               last;
    } hsu_cmd_t;

endpackage

// ----- src/hsu_if.sv -----
interface hsu_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_in;
    logic               last_in;

    modport source (output valid, value_in, last_in, input ready);
    modport sink (input valid, value_in, last_in, output ready);
endinterface

interface hsu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic               last_out;
    logic               overflowed;

    modport source (output valid, value_out, last_out, overflowed, input ready);
    modport sink (input valid, value_out, last_out, overflowed, output ready);
endinterface

interface hsu_cfg_if;
    logic valid;
    logic ready;
    logic unique_only;

    modport source (output valid, unique_only, input ready);
    modport sink (input valid, unique_only, output ready);
endinterface

// ----- src/heap_sort_with_unique_filter.sv -----
// channel   dir  fields                                  beat when
// in_ch     in   value_in[31:0] signed, last_in          valid & ready
// out_ch    out  value_out[31:0] signed, last_out,       valid & ready
//                overflowed
// cfg_ch    in   unique_only                             valid & ready (ready tied high)
//
// loading: one cycle per beat through a small command queue, ready drops only when it fills
// sort: one cycle per heap level in the sift loop (two registered reads of the element ram
//   per level), plus the root read, hold and write-back states around each sift
// emit: one cycle per stored value after a registered read, then the held-back last
//   beat; stalls while out_ch is not taken
// reset clears counts, flags and the queue; the element ram keeps its contents
module heap_sort_with_unique_filter #(
    parameter int CAPACITY    = hsu_pkg::CAPACITY_DEF,
    parameter int QUEUE_DEPTH = hsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hsu_in_if.sink     in_ch,
    hsu_out_if.source  out_ch,
    hsu_cfg_if.sink    cfg_ch
);

    logic              uniq_cfg_reg;
    logic              uniq_cfg_next;
    logic              q_push_valid;
    logic              q_push_ready;
    hsu_pkg::hsu_cmd_t q_push_cmd;
    logic              q_pop_valid;
    logic              q_pop_ready;
    hsu_pkg::hsu_cmd_t q_pop_cmd;

    assign cfg_ch.ready  = 1'b1;
    assign uniq_cfg_next = cfg_ch.valid ? cfg_ch.unique_only : uniq_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uniq_cfg_reg <= 1'b0;
        end
        else
        begin
            uniq_cfg_reg <= uniq_cfg_next;
        end
    end

    hsu_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (q_push_valid),
        .push_cmd   (q_push_cmd),
        .push_ready (q_push_ready)
    );

    hsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_cmd   (q_push_cmd),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_cmd    (q_pop_cmd),
        .pop_ready  (q_pop_ready)
    );

    hsu_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_pop_valid),
        .cmd       (q_pop_cmd),
        .cmd_ready (q_pop_ready),
        .uniq_cfg  (uniq_cfg_reg),
        .out_ch    (out_ch)
    );

endmodule

// ----- src/hsu_front.sv -----
module hsu_front #(
    parameter int CAPACITY = hsu_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    hsu_in_if.sink            in_ch,
    output logic              push_valid,
    output hsu_pkg::hsu_cmd_t push_cmd,
    input  logic              push_ready
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          accept;
    logic          keep;

    assign keep          = cnt_reg < CW'(CAPACITY);
    assign accept        = in_ch.valid && push_ready;
    assign in_ch.ready   = push_ready;
    assign push_valid    = in_ch.valid;
    assign push_cmd.value = in_ch.value_in;
    assign push_cmd.keep  = keep;
    assign push_cmd.last  = in_ch.last_in;

    // set boundary restarts the fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (in_ch.last_in)
            begin
                cnt_next = '0;
            end
            else if (keep)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/hsu_fifo.sv -----
module hsu_fifo #(
    parameter int DEPTH = hsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  hsu_pkg::hsu_cmd_t push_cmd,
    output logic              push_ready,
    output logic              pop_valid,
    output hsu_pkg::hsu_cmd_t pop_cmd,
    input  logic              pop_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    hsu_pkg::hsu_cmd_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = fill_reg != NW'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/hsu_back.sv -----
module hsu_back #(
    parameter int CAPACITY = hsu_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  hsu_pkg::hsu_cmd_t cmd,
    output logic              cmd_ready,
    input  logic              uniq_cfg,
    hsu_out_if.source         out_ch
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = AW + 2;

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_RD_ROOT = 4'd1;
    localparam logic [3:0] S_HELD    = 4'd2;
    localparam logic [3:0] S_CMP     = 4'd3;
    localparam logic [3:0] S_WR      = 4'd4;
    localparam logic [3:0] S_SWAP_RD = 4'd5;
    localparam logic [3:0] S_SWAP    = 4'd6;
    localparam logic [3:0] S_EM_RD   = 4'd7;
    localparam logic [3:0] S_EM_CHK  = 4'd8;
    localparam logic [3:0] S_EM_LAST = 4'd9;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd0_q;
    logic signed [31:0] rd1_q;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               run_ovf_reg, run_ovf_next;
    logic               uniq_reg, uniq_next;
    logic               build_reg, build_next;
    logic [AW-1:0]      nm1_reg, nm1_next;
    logic [AW-1:0]      end_reg, end_next;
    logic [AW-1:0]      root_reg, root_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [KW-1:0]      child_reg, child_next;
    logic signed [31:0] held_reg, held_next;
    logic signed [31:0] pend_reg, pend_next;

    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic [AW-1:0]      ra0;
    logic [AW-1:0]      ra1;
    logic               push;
    logic               push_last;
    logic               out_free;

    logic [AW-1:0]      nm1_w;
    logic [CW-1:0]      n_w;
    logic [AW-1:0]      root_w;
    logic [KW-1:0]      child0_w;
    logic               has_right;
    logic               pick_right;
    logic signed [31:0] pick_val;
    logic [KW-1:0]      pick_idx;
    logic [KW-1:0]      child_n;
    logic [AW-1:0]      end_m1;
    logic               need_out;

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign cmd_ready  = state_reg == S_LOAD;

    assign nm1_w      = cmd.keep ? cnt_reg[AW-1:0] : AW'(CAPACITY - 1);
    assign n_w        = CW'(nm1_w) + CW'(1);
    assign root_w     = AW'((n_w >> 1) - CW'(1));
    assign child0_w   = (KW'(root_reg) << 1) + KW'(1);
    assign has_right  = child_reg < KW'(end_reg);
    assign pick_right = has_right && (rd0_q < rd1_q);
    assign pick_val   = pick_right ? rd1_q : rd0_q;
    assign pick_idx   = child_reg + KW'(pick_right);
    assign child_n    = (pick_idx << 1) + KW'(1);
    assign end_m1     = end_reg - AW'(1);
    // the first sorted value is always kept
    assign need_out   = (i_reg != '0) && (!uniq_reg || (rd0_q != pend_reg));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        run_ovf_next = run_ovf_reg;
        uniq_next    = uniq_reg;
        build_next   = build_reg;
        nm1_next     = nm1_reg;
        end_next     = end_reg;
        root_next    = root_reg;
        pos_next     = pos_reg;
        i_next       = i_reg;
        child_next   = child_reg;
        held_next    = held_reg;
        pend_next    = pend_reg;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        ra0          = '0;
        ra1          = '0;
        push         = 1'b0;
        push_last    = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                if (cmd_valid)
                begin
                    if (cmd.keep)
                    begin
                        mem_we   = 1'b1;
                        mem_wa   = cnt_reg[AW-1:0];
                        mem_wd   = cmd.value;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (cmd.last)
                    begin
                        run_ovf_next = ovf_reg | !cmd.keep;
                        uniq_next    = uniq_cfg;
                        nm1_next     = nm1_w;
                        end_next     = nm1_w;
                        root_next    = root_w;
                        build_next   = 1'b1;
                        i_next       = '0;
                        cnt_next     = '0;
                        ovf_next     = 1'b0;
                        state_next   = (nm1_w == '0) ? S_EM_RD : S_RD_ROOT;
                    end
                end
            end
            S_RD_ROOT:
            begin
                ra0        = root_reg;
                state_next = S_HELD;
            end
            S_HELD:
            begin
                held_next = rd0_q;
                pos_next  = root_reg;
                if (child0_w > KW'(end_reg))
                begin
                    state_next = S_WR;
                end
                else
                begin
                    child_next = child0_w;
                    ra0        = child0_w[AW-1:0];
                    ra1        = AW'(child0_w + KW'(1));
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // one heap level per cycle: larger child moves up into the hole
                if (held_reg < pick_val)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = pos_reg;
                    mem_wd   = pick_val;
                    pos_next = pick_idx[AW-1:0];
                    if (child_n <= KW'(end_reg))
                    begin
                        child_next = child_n;
                        ra0        = child_n[AW-1:0];
                        ra1        = AW'(child_n + KW'(1));
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                mem_wd = held_reg;
                if (build_reg)
                begin
                    if (root_reg == '0)
                    begin
                        build_next = 1'b0;
                        state_next = S_SWAP_RD;
                    end
                    else
                    begin
                        root_next  = root_reg - AW'(1);
                        state_next = S_RD_ROOT;
                    end
                end
                else if (end_reg == '0)
                begin
                    i_next     = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    state_next = S_SWAP_RD;
                end
            end
            S_SWAP_RD:
            begin
                ra0        = '0;
                ra1        = end_reg;
                state_next = S_SWAP;
            end
            S_SWAP:
            begin
                // max goes to the tail, old tail sifts down from the root
                mem_we    = 1'b1;
                mem_wa    = end_reg;
                mem_wd    = rd0_q;
                held_next = rd1_q;
                pos_next  = '0;
                end_next  = end_m1;
                if (end_m1 == '0)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    child_next = KW'(1);
                    ra0        = AW'(1);
                    ra1        = AW'(2);
                    state_next = S_CMP;
                end
            end
            S_EM_RD:
            begin
                ra0        = i_reg;
                state_next = S_EM_CHK;
            end
            S_EM_CHK:
            begin
                // hold one value back so the run's tail can be marked
                if (!need_out || out_free)
                begin
                    push      = need_out;
                    pend_next = rd0_q;
                    if (i_reg == nm1_reg)
                    begin
                        state_next = S_EM_LAST;
                    end
                    else
                    begin
                        i_next = i_reg + AW'(1);
                        ra0    = i_reg + AW'(1);
                    end
                end
                else
                begin
                    ra0 = i_reg;
                end
            end
            S_EM_LAST:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd0_q <= mem[ra0];
        rd1_q <= mem[ra1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            build_reg <= build_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_ovf_reg <= run_ovf_next;
        uniq_reg    <= uniq_next;
        nm1_reg     <= nm1_next;
        end_reg     <= end_next;
        root_reg    <= root_next;
        pos_reg     <= pos_next;
        i_reg       <= i_next;
        child_reg   <= child_next;
        held_reg    <= held_next;
        pend_reg    <= pend_next;
        if (push)
        begin
            out_value_reg <= pend_reg;
            out_last_reg  <= push_last;
            out_ovf_reg   <= run_ovf_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.value_out  = out_value_reg;
    assign out_ch.last_out   = out_last_reg;
    assign out_ch.overflowed = out_ovf_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_child_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (child_reg <= KW'(end_reg)))
        else $error("sift compare past heap end");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result overwrites an untaken beat");

    a_set_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && cmd_valid && cmd.last)
        |=> (cnt_reg == '0 && !ovf_reg && state_reg != S_LOAD))
        else $error("set close did not start the sort");

endmodule
